// ===== design/dns_response_address_parser_defines.svh =====
// Assertion macros used by the DNS response address parser top level.
`ifndef DNS_RESPONSE_ADDRESS_PARSER_DEFINES_SVH
`define DNS_RESPONSE_ADDRESS_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DNSRAP_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DNSRAP_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== design/dnsrap_pkg.sv =====
// Package with the types, codes and constant tables of the DNS response address parser.
`timescale 1ns / 1ps

package dnsrap_pkg;

   // Verdict codes carried by a result item.
   typedef enum logic [1:0] {
      VERDICT_FOUND     = 2'd0,
      VERDICT_ERROR     = 2'd1,
      VERDICT_OTHER     = 2'd2,
      VERDICT_TRUNCATED = 2'd3
   } verdict_type;

   // Parse phases, one-hot.
   typedef enum logic [10:0] {
      PH_HEADER = 11'b000_0000_0001,
      PH_QLEN   = 11'b000_0000_0010,
      PH_QLABEL = 11'b000_0000_0100,
      PH_QTAIL  = 11'b000_0000_1000,
      PH_AFIRST = 11'b000_0001_0000,
      PH_APTR   = 11'b000_0010_0000,
      PH_ALEN   = 11'b000_0100_0000,
      PH_ALABEL = 11'b000_1000_0000,
      PH_FIXED  = 11'b001_0000_0000,
      PH_RDATA  = 11'b010_0000_0000,
      PH_ADDR   = 11'b100_0000_0000
   } phase_type;

   // Configuration register indexes.
   localparam logic REG_QUERY_ID = 1'b0;

   // Header layout and masks.
   localparam logic [3:0] HDR_ID_LOW_OFFSET  = 4'd1;
   localparam logic [3:0] HDR_RCODE_OFFSET   = 4'd3;
   localparam logic [3:0] HDR_ANCOUNT_OFFSET = 4'd7;
   localparam logic [3:0] HDR_LAST_OFFSET    = 4'd11;
   localparam logic [7:0] RCODE_MASK         = 8'h0f;
   localparam logic [7:0] POINTER_MASK       = 8'hc0;

   // Fixed record fields: type, class, TTL, data length.
   localparam logic [3:0] FIX_LAST_OFFSET    = 4'd9;
   localparam logic [3:0] FIX_LENGTH_OFFSET  = 4'd8;
   localparam logic [3:0] ADDR_LAST_OFFSET   = 4'd3;
   localparam logic [15:0] QTAIL_BYTES       = 16'd4;

   // Result item with its valid flag.
   typedef struct packed {
      logic        valid;
      verdict_type verdict;
      logic [31:0] address;
   } result_type;

   // Value that a fixed field byte must have for an IPv4 address record.
   function automatic logic [7:0] fixed_want(input logic [3:0] offset);
      logic [7:0] value;
      unique case (offset)
         4'd1, 4'd3: value = 8'd1;
         4'd9:       value = 8'd4;
         default:    value = 8'd0;
      endcase
      return value;
   endfunction

   // Whether a fixed field byte takes part in the address record check.
   function automatic logic fixed_check(input logic [3:0] offset);
      logic value;
      unique case (offset)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd8, 4'd9: value = 1'b1;
         default:                            value = 1'b0;
      endcase
      return value;
   endfunction

endpackage

// ===== design/dnsrap_parser.sv =====
// Byte-wise DNS response parser: state registers and the per-item next-state logic.
`timescale 1ns / 1ps

module dnsrap_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              data_byte,
   input  logic                    last_byte,
   input  logic [7:0]              query_id,
   output dnsrap_pkg::result_type  result
);

   dnsrap_pkg::phase_type   phase_ff, phase_in;
   logic [3:0]              offset_ff, offset_in;
   logic [15:0]             skip_ff, skip_in;
   logic [7:0]              answers_ff, answers_in;
   logic                    match_ff, match_in;
   logic [15:0]             length_ff, length_in;
   logic [31:0]             address_ff, address_in;
   logic                    undecided_ff, undecided_in;
   dnsrap_pkg::verdict_type verdict_ff, verdict_in;

   logic [3:0]  fix_offset;
   logic [15:0] skip_dec;
   logic [7:0]  answers_dec;
   logic [15:0] length_next;
   logic        match_next;

   assign fix_offset  = (offset_ff > dnsrap_pkg::FIX_LAST_OFFSET) ? 4'd0 : offset_ff;
   assign skip_dec    = skip_ff - 16'd1;
   assign answers_dec = answers_ff - 8'd1;
   assign length_next = {length_ff[7:0], data_byte};
   assign match_next  = match_ff && !(dnsrap_pkg::fixed_check(fix_offset) &&
                                      (data_byte != dnsrap_pkg::fixed_want(fix_offset)));

   // Next state and result for the item being accepted.
   always_comb begin
      phase_in     = phase_ff;
      offset_in    = offset_ff;
      skip_in      = skip_ff;
      answers_in   = answers_ff;
      match_in     = match_ff;
      length_in    = length_ff;
      address_in   = address_ff;
      undecided_in = undecided_ff;
      verdict_in   = verdict_ff;
      result       = '0;
      if (accept) begin
         if (undecided_ff) begin
            unique case (phase_ff)
               dnsrap_pkg::PH_HEADER: begin
                  if (offset_ff == dnsrap_pkg::HDR_ID_LOW_OFFSET && data_byte != query_id) begin
                     undecided_in = 1'b0;
                     verdict_in   = dnsrap_pkg::VERDICT_OTHER;
                  end else if (offset_ff == dnsrap_pkg::HDR_RCODE_OFFSET &&
                               (data_byte & dnsrap_pkg::RCODE_MASK) != 8'd0) begin
                     undecided_in = 1'b0;
                     verdict_in   = dnsrap_pkg::VERDICT_ERROR;
                  end else begin
                     if (offset_ff == dnsrap_pkg::HDR_ANCOUNT_OFFSET) begin
                        answers_in = data_byte;
                     end
                     if (offset_ff >= dnsrap_pkg::HDR_LAST_OFFSET) begin
                        phase_in  = dnsrap_pkg::PH_QLEN;
                        offset_in = 4'd0;
                     end else begin
                        offset_in = offset_ff + 4'd1;
                     end
                  end
               end
               dnsrap_pkg::PH_QLEN: begin
                  if (data_byte == 8'd0) begin
                     skip_in  = dnsrap_pkg::QTAIL_BYTES;
                     phase_in = dnsrap_pkg::PH_QTAIL;
                  end else begin
                     skip_in  = {8'd0, data_byte};
                     phase_in = dnsrap_pkg::PH_QLABEL;
                  end
               end
               dnsrap_pkg::PH_QLABEL: begin
                  skip_in = skip_dec;
                  if (skip_dec == 16'd0) begin
                     phase_in = dnsrap_pkg::PH_QLEN;
                  end
               end
               dnsrap_pkg::PH_QTAIL: begin
                  skip_in = skip_dec;
                  if (skip_dec == 16'd0) begin
                     if (answers_ff == 8'd0) begin
                        undecided_in = 1'b0;
                        verdict_in   = dnsrap_pkg::VERDICT_ERROR;
                     end else begin
                        phase_in = dnsrap_pkg::PH_AFIRST;
                     end
                  end
               end
               dnsrap_pkg::PH_AFIRST: begin
                  if ((data_byte & dnsrap_pkg::POINTER_MASK) != 8'd0) begin
                     phase_in = dnsrap_pkg::PH_APTR;
                  end else if (data_byte == 8'd0) begin
                     phase_in  = dnsrap_pkg::PH_FIXED;
                     offset_in = 4'd0;
                     match_in  = 1'b1;
                     length_in = 16'd0;
                  end else begin
                     skip_in  = {8'd0, data_byte};
                     phase_in = dnsrap_pkg::PH_ALABEL;
                  end
               end
               dnsrap_pkg::PH_APTR: begin
                  phase_in  = dnsrap_pkg::PH_FIXED;
                  offset_in = 4'd0;
                  match_in  = 1'b1;
                  length_in = 16'd0;
               end
               dnsrap_pkg::PH_ALEN: begin
                  if (data_byte == 8'd0) begin
                     phase_in  = dnsrap_pkg::PH_FIXED;
                     offset_in = 4'd0;
                     match_in  = 1'b1;
                     length_in = 16'd0;
                  end else begin
                     skip_in  = {8'd0, data_byte};
                     phase_in = dnsrap_pkg::PH_ALABEL;
                  end
               end
               dnsrap_pkg::PH_ALABEL: begin
                  skip_in = skip_dec;
                  if (skip_dec == 16'd0) begin
                     phase_in = dnsrap_pkg::PH_ALEN;
                  end
               end
               dnsrap_pkg::PH_FIXED: begin
                  match_in = match_next;
                  if (fix_offset >= dnsrap_pkg::FIX_LENGTH_OFFSET) begin
                     length_in = length_next;
                  end
                  if (fix_offset == dnsrap_pkg::FIX_LAST_OFFSET) begin
                     offset_in = 4'd0;
                     if (match_next) begin
                        address_in = 32'd0;
                        phase_in   = dnsrap_pkg::PH_ADDR;
                     end else if (length_next == 16'd0) begin
                        answers_in = answers_dec;
                        if (answers_dec == 8'd0) begin
                           undecided_in = 1'b0;
                           verdict_in   = dnsrap_pkg::VERDICT_ERROR;
                        end else begin
                           phase_in = dnsrap_pkg::PH_AFIRST;
                        end
                     end else begin
                        skip_in  = length_next;
                        phase_in = dnsrap_pkg::PH_RDATA;
                     end
                  end else begin
                     offset_in = fix_offset + 4'd1;
                  end
               end
               dnsrap_pkg::PH_RDATA: begin
                  skip_in = skip_dec;
                  if (skip_dec == 16'd0) begin
                     answers_in = answers_dec;
                     if (answers_dec == 8'd0) begin
                        undecided_in = 1'b0;
                        verdict_in   = dnsrap_pkg::VERDICT_ERROR;
                     end else begin
                        phase_in = dnsrap_pkg::PH_AFIRST;
                     end
                  end
               end
               dnsrap_pkg::PH_ADDR: begin
                  address_in = {address_ff[23:0], data_byte};
                  if (offset_ff >= dnsrap_pkg::ADDR_LAST_OFFSET) begin
                     undecided_in = 1'b0;
                     verdict_in   = dnsrap_pkg::VERDICT_FOUND;
                  end else begin
                     offset_in = offset_ff + 4'd1;
                  end
               end
               default: begin
                  phase_in = dnsrap_pkg::PH_HEADER;
               end
            endcase
         end

         // The last byte reports the verdict and re-arms the parser.
         if (last_byte) begin
            result.valid   = 1'b1;
            result.verdict = undecided_in ? dnsrap_pkg::VERDICT_TRUNCATED : verdict_in;
            result.address = (!undecided_in && verdict_in == dnsrap_pkg::VERDICT_FOUND) ?
                             address_in : 32'd0;
            phase_in     = dnsrap_pkg::PH_HEADER;
            offset_in    = 4'd0;
            skip_in      = 16'd0;
            answers_in   = 8'd0;
            match_in     = 1'b0;
            length_in    = 16'd0;
            address_in   = 32'd0;
            undecided_in = 1'b1;
            verdict_in   = dnsrap_pkg::VERDICT_ERROR;
         end
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dnsrap_pkg::PH_HEADER;
         offset_ff    <= 4'd0;
         skip_ff      <= 16'd0;
         answers_ff   <= 8'd0;
         match_ff     <= 1'b0;
         length_ff    <= 16'd0;
         address_ff   <= 32'd0;
         undecided_ff <= 1'b1;
         verdict_ff   <= dnsrap_pkg::VERDICT_ERROR;
      end else begin
         phase_ff     <= phase_in;
         offset_ff    <= offset_in;
         skip_ff      <= skip_in;
         answers_ff   <= answers_in;
         match_ff     <= match_in;
         length_ff    <= length_in;
         address_ff   <= address_in;
         undecided_ff <= undecided_in;
         verdict_ff   <= verdict_in;
      end
   end

endmodule

// ===== design/dns_response_address_parser.sv =====
// Top level of the DNS response address parser: channels, register port and result buffer.
//
// Usage: the DNS message enters on the req_ channel one byte per item, with
// req_last_byte high on its final byte. Only that final item produces a
// result on the rsp_ channel: a verdict (address found, error or no
// address, other query, truncated) and the IPv4 address, zero unless found.
// The low byte of the expected message id is written through the csr_ port
// at byte address 0 while no message is in flight.
// Throughput is one byte per cycle while req_stall is low: each byte
// updates the parser state in the cycle it is accepted. The last byte's
// result is registered in the output register driving rsp_valid, or in
// a one-entry skid register while it is held; a stalled receiver costs
// nothing until both are full; req_stall then rises until output drains.
// Synchronous reset clears the parser to the start of a message, empties
// both result registers and sets the id register to zero.
`timescale 1ns / 1ps
`include "dns_response_address_parser_defines.svh"

module dns_response_address_parser (
   input  logic        clock,
   input  logic        reset,
   // Byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_verdict,
   output logic [31:0] rsp_address,
   // Register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                   req_accept;
   logic                   rsp_pop;
   logic                   csr_write;
   logic [7:0]             query_id_ff, query_id_in;
   dnsrap_pkg::result_type result;
   dnsrap_pkg::result_type out_ff, out_in;
   dnsrap_pkg::result_type skid_ff, skid_in;

   assign req_stall  = skid_ff.valid;
   assign req_accept = req_valid && !req_stall;
   assign rsp_pop    = out_ff.valid && !rsp_stall;

   // Register port: always ready, one id register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == dnsrap_pkg::REG_QUERY_ID) ? {24'd0, query_id_ff} : 32'd0;
   assign query_id_in = (csr_write && csr_paddr[2] == dnsrap_pkg::REG_QUERY_ID) ?
                        csr_pwdata[7:0] : query_id_ff;

   // Parser.
   dnsrap_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .query_id  (query_id_ff),
      .result    (result)
   );

   // Output register and skid register for result items.
   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      if (!out_ff.valid || rsp_pop) begin
         if (skid_ff.valid) begin
            out_in        = skid_ff;
            skid_in.valid = 1'b0;
         end else begin
            out_in = result;
         end
      end else if (result.valid) begin
         skid_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_id_ff <= 8'd0;
         out_ff      <= '0;
         skid_ff     <= '0;
      end else begin
         query_id_ff <= query_id_in;
         out_ff      <= out_in;
         skid_ff     <= skid_in;
      end
   end

   assign rsp_valid   = out_ff.valid;
   assign rsp_verdict = out_ff.verdict;
   assign rsp_address = out_ff.address;

   // Checks on the result buffer and the result contents.
   `DNSRAP_ASSERT_NOW(a_skid_behind_out, skid_ff.valid, out_ff.valid, "skid full while output empty")
   `DNSRAP_ASSERT_NEXT(a_result_from_last, !out_ff.valid && !(req_accept && req_last_byte), !out_ff.valid, "result without a last byte")
   `DNSRAP_ASSERT_NOW(a_address_only_found, out_ff.valid && out_ff.verdict != dnsrap_pkg::VERDICT_FOUND, out_ff.address == 32'd0, "address set without a found verdict")
   `DNSRAP_ASSERT_NEXT(a_skid_fill, !skid_ff.valid && !(req_accept && req_last_byte), !skid_ff.valid, "skid filled without a last byte")

endmodule
